FILE: hdl/sqd_pkg.sv
// ---------------------------------------------------------------------------
// sqd_pkg: shared constants and types
// Queue geometry, derived widths and the control/status bundles between the
// controller and the datapath.
// ---------------------------------------------------------------------------
package sqd_pkg;

   localparam int MAX_QUEUES  = 8;
   localparam int QUEUE_DEPTH = 64;

   // queue index, loop counter (must reach MAX_QUEUES), head, length
   localparam int QIDX_W = (MAX_QUEUES > 1) ? $clog2(MAX_QUEUES) : 1;
   localparam int LOOP_W = $clog2(MAX_QUEUES + 1);
   localparam int HEAD_W = $clog2(QUEUE_DEPTH);
   localparam int LEN_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int ADDR_W = $clog2(MAX_QUEUES * QUEUE_DEPTH);
   localparam int WORD_W = 32;   // {item id, arrive time}
   localparam int MASK_W = 8;

   typedef struct packed {
      logic init;      // write the reset entry of queue 0
      logic load;      // take a tick
      logic scan;      // one step of the shortest-queue search
      logic enq;       // enqueue or drop the arrival
      logic next;      // skip to next queue
      logic rd;        // dequeue front of current queue
      logic emit_rec;  // present served record
      logic emit_sum;  // present summary, advance tick
   } sqd_cmd_type;

   typedef struct packed {
      logic scan_done;
      logic srv_done;
      logic srv_hit;
   } sqd_stat_type;

endpackage

FILE: hdl/sqd_ram.sv
// ---------------------------------------------------------------------------
// sqd_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
module sqd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

FILE: hdl/sqd_ctrl.sv
// ---------------------------------------------------------------------------
// sqd_ctrl: tick sequencer
// Walks each tick through search, enqueue, per-queue service and summary.
// ---------------------------------------------------------------------------
module sqd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  sqd_pkg::sqd_stat_type stat,
   output sqd_pkg::sqd_cmd_type  cmd
);
   import sqd_pkg::*;

   typedef enum logic [2:0] {
      ST_INIT, ST_IDLE, ST_SCAN, ST_CHK, ST_OUT
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_INIT: begin
            cmd.init = 1'b1;
            state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (stat.scan_done) begin
               cmd.enq  = 1'b1;
               state_in = ST_CHK;
            end else begin
               cmd.scan = 1'b1;
            end
         end
         ST_CHK: begin
            if (stat.srv_done) begin
               cmd.emit_sum = 1'b1;
               state_in     = ST_IDLE;
            end else if (stat.srv_hit) begin
               cmd.rd   = 1'b1;
               state_in = ST_OUT;
            end else begin
               cmd.next = 1'b1;
            end
         end
         ST_OUT: begin
            cmd.emit_rec = 1'b1;
            state_in     = ST_CHK;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         busy_ff  <= 1'b1;
      end else begin
         state_ff <= state_in;
         busy_ff  <= (state_in != ST_IDLE);
      end
   end

   assign busy = busy_ff;

endmodule

FILE: hdl/sqd_datapath.sv
// ---------------------------------------------------------------------------
// sqd_datapath: queue state, queue store and result registers
// Per-queue head, length, served count and front start time in registers;
// entries {id, arrive} in the queue store RAM.
// ---------------------------------------------------------------------------
module sqd_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  sqd_pkg::sqd_cmd_type  cmd,
   output sqd_pkg::sqd_stat_type stat,
   input  logic                  csr_we,
   input  logic [3:0]            csr_wdata,
   input  logic                  req_arrival,
   input  logic [7:0]            req_serve_mask,
   output logic                  rsp_strobe,
   output logic                  rsp_kind,
   output logic [2:0]            rsp_queue_index,
   output logic [15:0]           rsp_item_id,
   output logic [15:0]           rsp_arrive_time,
   output logic [15:0]           rsp_start_time,
   output logic [15:0]           rsp_leave_time,
   output logic [15:0]           rsp_served_total,
   output logic [6:0]            rsp_queue_length,
   output logic                  rsp_arrival_taken,
   output logic                  rsp_arrival_dropped,
   output logic                  rsp_last
);
   import sqd_pkg::*;

   localparam int DEPTH_RAM = MAX_QUEUES * QUEUE_DEPTH;

   logic [HEAD_W-1:0] head_ff   [MAX_QUEUES];
   logic [LEN_W-1:0]  count_ff  [MAX_QUEUES];
   logic [15:0]       served_ff [MAX_QUEUES];
   logic [15:0]       fstart_ff [MAX_QUEUES];
   logic [15:0]       tick_ff, next_id_ff, arr_id_ff;
   logic [3:0]        active_ff;
   logic              arrival_ff, taken_ff, dropped_ff;
   logic [MASK_W-1:0] mask_ff;
   logic [LOOP_W-1:0] idx_ff;
   logic [QIDX_W-1:0] chosen_ff;
   logic [LEN_W-1:0]  best_ff;

   // latched at dequeue, sent with the RAM read data
   logic [QIDX_W-1:0] rec_q_ff;
   logic [15:0]       rec_start_ff, rec_served_ff;
   logic [LEN_W-1:0]  rec_len_ff;

   logic [LOOP_W-1:0] n_eff;
   logic [QIDX_W-1:0] cur_q;
   logic              mask_bit;
   logic [HEAD_W:0]   tail_sum;
   logic [HEAD_W-1:0] tail_pos;
   logic [HEAD_W-1:0] head_nx;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [WORD_W-1:0] wr_data, rd_data;
   logic [15:0]       id_inc;

   always_comb begin
      if (active_ff == 4'd0) begin
         n_eff = LOOP_W'(1);
      end else if (32'(active_ff) > MAX_QUEUES) begin
         n_eff = LOOP_W'(MAX_QUEUES);
      end else begin
         n_eff = LOOP_W'(active_ff);
      end
   end

   assign cur_q    = idx_ff[QIDX_W-1:0];
   assign mask_bit = (32'(idx_ff) < MASK_W) ? mask_ff[idx_ff[2:0]] : 1'b0;

   assign stat.scan_done = (idx_ff >= n_eff);
   assign stat.srv_done  = (idx_ff >= n_eff);
   assign stat.srv_hit   = mask_bit && (count_ff[cur_q] != '0);

   // tail slot of the chosen queue, wrapped into the ring
   assign tail_sum = {1'b0, head_ff[chosen_ff]} + (HEAD_W+1)'(count_ff[chosen_ff]);
   assign tail_pos = (32'(tail_sum) >= QUEUE_DEPTH) ?
                     HEAD_W'(tail_sum - (HEAD_W+1)'(QUEUE_DEPTH)) : tail_sum[HEAD_W-1:0];
   assign head_nx  = (32'(head_ff[cur_q]) == QUEUE_DEPTH - 1) ? '0 :
                     HEAD_W'(head_ff[cur_q] + 1'b1);

   assign id_inc  = next_id_ff + 16'd1;
   assign wr_en   = cmd.init || (cmd.enq && arrival_ff &&
                    (32'(count_ff[chosen_ff]) < QUEUE_DEPTH));
   assign wr_addr = cmd.init ? '0 :
                    ADDR_W'(ADDR_W'(chosen_ff) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(tail_pos));
   assign wr_data = cmd.init ? '0 : {arr_id_ff, tick_ff};
   assign rd_addr = ADDR_W'(ADDR_W'(cur_q) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(head_ff[cur_q]));

   sqd_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH_RAM)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_QUEUES; i++) begin
            head_ff[i]   <= '0;
            count_ff[i]  <= (i == 0) ? LEN_W'(1) : '0;
            served_ff[i] <= '0;
            fstart_ff[i] <= '0;
         end
         tick_ff    <= '0;
         next_id_ff <= '0;
         active_ff  <= 4'd1;
         rsp_strobe <= 1'b0;
      end else begin
         rsp_strobe <= cmd.emit_rec || cmd.emit_sum;
         if (csr_we) begin
            active_ff <= csr_wdata;
         end
         if (cmd.load) begin
            arrival_ff <= req_arrival;
            mask_ff    <= req_serve_mask;
            idx_ff     <= LOOP_W'(1);
            chosen_ff  <= '0;
            best_ff    <= count_ff[0];
            taken_ff   <= 1'b0;
            dropped_ff <= 1'b0;
            arr_id_ff  <= req_arrival ? id_inc : '0;
            if (req_arrival) begin
               next_id_ff <= id_inc;
            end
         end
         if (cmd.scan) begin
            if (count_ff[cur_q] < best_ff) begin
               best_ff   <= count_ff[cur_q];
               chosen_ff <= cur_q;
            end
            idx_ff <= idx_ff + 1'b1;
         end
         if (cmd.enq) begin
            idx_ff <= '0;
            if (arrival_ff) begin
               if (32'(count_ff[chosen_ff]) >= QUEUE_DEPTH) begin
                  dropped_ff <= 1'b1;
               end else begin
                  taken_ff            <= 1'b1;
                  count_ff[chosen_ff] <= count_ff[chosen_ff] + 1'b1;
                  if (count_ff[chosen_ff] == '0) begin
                     fstart_ff[chosen_ff] <= tick_ff;
                  end
               end
            end
         end
         if (cmd.next) begin
            idx_ff <= idx_ff + 1'b1;
         end
         if (cmd.rd) begin
            rec_q_ff      <= cur_q;
            rec_start_ff  <= fstart_ff[cur_q];
            rec_len_ff    <= count_ff[cur_q] - 1'b1;
            rec_served_ff <= (served_ff[cur_q] == 16'hFFFF) ? 16'hFFFF
                                                            : served_ff[cur_q] + 16'd1;
            head_ff[cur_q]  <= head_nx;
            count_ff[cur_q] <= count_ff[cur_q] - 1'b1;
            if (served_ff[cur_q] != 16'hFFFF) begin
               served_ff[cur_q] <= served_ff[cur_q] + 16'd1;
            end
            // new front reaches the head now
            if (count_ff[cur_q] > LEN_W'(1)) begin
               fstart_ff[cur_q] <= tick_ff;
            end
         end
         if (cmd.emit_rec) begin
            idx_ff <= idx_ff + 1'b1;
         end
         if (cmd.emit_sum) begin
            tick_ff <= tick_ff + 16'd1;
         end
      end
   end

   // result registers: payload only
   always_ff @(posedge clock) begin
      if (cmd.emit_rec) begin
         rsp_kind            <= 1'b0;
         rsp_queue_index     <= 3'(rec_q_ff);
         rsp_item_id         <= rd_data[31:16];
         rsp_arrive_time     <= rd_data[15:0];
         rsp_start_time      <= rec_start_ff;
         rsp_leave_time      <= tick_ff;
         rsp_served_total    <= rec_served_ff;
         rsp_queue_length    <= 7'(rec_len_ff);
         rsp_arrival_taken   <= 1'b0;
         rsp_arrival_dropped <= 1'b0;
         rsp_last            <= 1'b0;
      end else if (cmd.emit_sum) begin
         rsp_kind            <= 1'b1;
         rsp_queue_index     <= arrival_ff ? 3'(chosen_ff) : 3'd0;
         rsp_item_id         <= arr_id_ff;
         rsp_arrive_time     <= '0;
         rsp_start_time      <= '0;
         rsp_leave_time      <= tick_ff;
         rsp_served_total    <= '0;
         rsp_queue_length    <= arrival_ff ? 7'(count_ff[chosen_ff]) : 7'd0;
         rsp_arrival_taken   <= taken_ff;
         rsp_arrival_dropped <= dropped_ff;
         rsp_last            <= 1'b1;
      end
   end

   a_rd_then_emit: assert property (@(posedge clock) disable iff (reset)
      cmd.rd |=> cmd.emit_rec)
      else $error("dequeue not followed by record");

   a_take_or_drop: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_sum |-> !(taken_ff && dropped_ff) && (taken_ff || dropped_ff) == arrival_ff)
      else $error("arrival outcome inconsistent");

   a_dequeue_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.rd |-> count_ff[cur_q] != '0 && idx_ff < n_eff)
      else $error("dequeue from empty or inactive queue");

endmodule

FILE: hdl/shortest_queue_dispatcher.sv
// ---------------------------------------------------------------------------
// shortest_queue_dispatcher: join-shortest-queue dispatch over up to 8 queues
// One start beat is one time tick. The block takes a tick when start is high
// and busy is low, then drops busy again once the tick's summary is on the
// result ports. Each tick is taken, then the shortest-queue search runs over
// each active queue, the arrival is enqueued or dropped, the queues are
// walked for service with an extra step per service for the registered read
// of the queue store, and the summary closes the tick. Each result is marked
// by an rsp_strobe beat and cannot be held off; the summary (rsp_last) ends
// a tick.
// After reset, busy is high for one cycle while queue 0's first entry is
// written.
// ---------------------------------------------------------------------------
module shortest_queue_dispatcher (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_arrival,
   input  logic [7:0]  req_serve_mask,
   input  logic        csr_we,
   input  logic [3:0]  csr_wdata,
   output logic        rsp_strobe,
   output logic        rsp_kind,
   output logic [2:0]  rsp_queue_index,
   output logic [15:0] rsp_item_id,
   output logic [15:0] rsp_arrive_time,
   output logic [15:0] rsp_start_time,
   output logic [15:0] rsp_leave_time,
   output logic [15:0] rsp_served_total,
   output logic [6:0]  rsp_queue_length,
   output logic        rsp_arrival_taken,
   output logic        rsp_arrival_dropped,
   output logic        rsp_last
);
   import sqd_pkg::*;

   sqd_cmd_type  cmd;
   sqd_stat_type stat;

   sqd_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   sqd_datapath u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .csr_we              (csr_we),
      .csr_wdata           (csr_wdata),
      .req_arrival         (req_arrival),
      .req_serve_mask      (req_serve_mask),
      .rsp_strobe          (rsp_strobe),
      .rsp_kind            (rsp_kind),
      .rsp_queue_index     (rsp_queue_index),
      .rsp_item_id         (rsp_item_id),
      .rsp_arrive_time     (rsp_arrive_time),
      .rsp_start_time      (rsp_start_time),
      .rsp_leave_time      (rsp_leave_time),
      .rsp_served_total    (rsp_served_total),
      .rsp_queue_length    (rsp_queue_length),
      .rsp_arrival_taken   (rsp_arrival_taken),
      .rsp_arrival_dropped (rsp_arrival_dropped),
      .rsp_last            (rsp_last)
   );

endmodule
